### rtl/hpt_pkg.sv
package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    // products shifted down, three of them plus a translation, never exceed this
    localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
    localparam int QUO_W     = 32;
    localparam int PRE_SH    = QUO_W - FRAC_BITS;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int REG_W     = 64;
    localparam int MAC_LAT   = 2;
    localparam int DIV_LAT   = QUO_W + 2;
    localparam int LAT       = MAC_LAT + DIV_LAT;

    localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + 32));

    typedef enum logic [IDX_W-1:0] {
        REG_R0_C01 = 3'd0,
        REG_R0_C23 = 3'd1,
        REG_R1_C01 = 3'd2,
        REG_R1_C23 = 3'd3,
        REG_R2_C01 = 3'd4,
        REG_R2_C23 = 3'd5,
        REG_R3_C01 = 3'd6,
        REG_R3_C23 = 3'd7
    } reg_idx_t;

    typedef logic [3:0][3:0][COORD_W-1:0] mat_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] den;
        logic [QUO_W-1:0] bits;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             big;
        logic             zero;
    } div_stage_t;

endpackage

### rtl/hpt_mac.sv
module hpt_mac (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [hpt_pkg::COORD_W-1:0]          point_x,
    input  logic [hpt_pkg::COORD_W-1:0]          point_y,
    input  logic [hpt_pkg::COORD_W-1:0]          point_z,
    input  hpt_pkg::mat_t                        mat,
    output logic signed [hpt_pkg::SUM_W-1:0]     acc [4]
);

    logic signed [hpt_pkg::PROD_W-1:0]  prod_reg [3][4];
    logic signed [hpt_pkg::COORD_W-1:0] trans_reg [4];
    logic signed [hpt_pkg::SUM_W-1:0]   acc_reg [4];
    logic signed [hpt_pkg::SUM_W-1:0]   acc_next [4];
    logic        [hpt_pkg::COORD_W-1:0] pt [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // stage 1: twelve exact products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[k][c] <= hpt_pkg::PROD_W'($signed(pt[k]))
                                    * hpt_pkg::PROD_W'($signed(mat[k][c]));
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                trans_reg[c] <= $signed(mat[3][c]);
            end
        end
    end

    // stage 2: floor-shift each product and add the translation
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc_next[c] = hpt_pkg::SUM_W'(trans_reg[c]);
            for (int k = 0; k < 3; k++)
            begin
                acc_next[c] = acc_next[c] + hpt_pkg::SUM_W'(
                    $signed(prod_reg[k][c][hpt_pkg::PROD_W-1:hpt_pkg::FRAC_BITS]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                acc_reg[c] <= acc_next[c];
            end
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/hpt_div.sv
module hpt_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [hpt_pkg::SUM_W-1:0]  num,
    input  logic signed [hpt_pkg::SUM_W-1:0]  den,
    output logic [hpt_pkg::QUO_W-1:0]         quo,
    output logic                              sat,
    output logic                              zero
);

    localparam int SW = hpt_pkg::SUM_W;
    localparam int QW = hpt_pkg::QUO_W;
    localparam int SH = hpt_pkg::PRE_SH;

    hpt_pkg::div_stage_t st_reg [QW+1];
    hpt_pkg::div_stage_t st_next [QW+1];
    logic [QW-1:0] quo_reg, quo_next;
    logic          sat_reg, sat_next, zero_reg;

    logic [SW-1:0]    un, ud;
    logic [SW+SH-1:0] num_ext, den_ext;
    logic [SW:0]      trial [QW];
    logic             ge [QW];
    logic [QW:0]      limit;

    // prep: magnitudes, sign, and the quotient-too-large test,
    // then one quotient bit per stage
    always_comb
    begin
        un      = num[SW-1] ? SW'(-num) : SW'(num);
        ud      = den[SW-1] ? SW'(-den) : SW'(den);
        num_ext = {{SH{1'b0}}, un};
        den_ext = {ud, {SH{1'b0}}};
        st_next[0].rem  = un >> SH;
        st_next[0].den  = ud;
        st_next[0].bits = {un[SH-1:0], {hpt_pkg::FRAC_BITS{1'b0}}};
        st_next[0].quo  = '0;
        st_next[0].neg  = num[SW-1] ^ den[SW-1];
        st_next[0].big  = num_ext >= den_ext;
        st_next[0].zero = ud == '0;

        for (int i = 0; i < QW; i++)
        begin
            trial[i] = {st_reg[i].rem, st_reg[i].bits[QW-1]};
            ge[i]    = trial[i] >= {1'b0, st_reg[i].den};
            st_next[i+1]      = st_reg[i];
            st_next[i+1].rem  = ge[i] ? SW'(trial[i] - {1'b0, st_reg[i].den})
                                      : SW'(trial[i]);
            st_next[i+1].bits = st_reg[i].bits << 1;
            st_next[i+1].quo  = {st_reg[i].quo[QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QW; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // clamp and apply the sign
    always_comb
    begin
        limit = st_reg[QW].neg ? (QW+1)'(33'h0_8000_0000) : (QW+1)'(33'h0_7FFF_FFFF);
        if (st_reg[QW].big || {1'b0, st_reg[QW].quo} > limit)
        begin
            sat_next = 1'b1;
            quo_next = QW'(limit);
        end
        else
        begin
            sat_next = 1'b0;
            quo_next = st_reg[QW].quo;
        end
        if (st_reg[QW].neg)
        begin
            quo_next = QW'(-quo_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg  <= quo_next;
            sat_reg  <= sat_next;
            zero_reg <= st_reg[QW].zero;
        end
    end

    assign quo  = quo_reg;
    assign sat  = sat_reg;
    assign zero = zero_reg;

endmodule

### rtl/homogeneous_point_transform.sv
// An accepted input word passes 2 multiply/accumulate stages, 1 divide prep,
// 32 quotient-bit stages and 1 clamp. Throughput: one word per cycle unless
// the output stalls; the 32-stage restoring divider sets the depth.
// Reset (rst_n low, asynchronous): the pipeline empties and the matrix
// returns to identity.
module homogeneous_point_transform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  logic [95:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [95:0]                   m_axis_tdata,
    // divide_by_zero [0], saturated [1]
    output logic [1:0]                    m_axis_tuser,
    input  logic                          cfg_we,
    input  logic [hpt_pkg::IDX_W-1:0]     cfg_index,
    input  logic [hpt_pkg::REG_W-1:0]     cfg_data
);

    localparam int LAT = hpt_pkg::LAT;
    localparam int CW  = hpt_pkg::COORD_W;

    logic [hpt_pkg::REG_W-1:0] cfg_reg [hpt_pkg::NUM_REGS];
    hpt_pkg::mat_t             mat;
    logic [LAT-1:0]            vld_reg;
    logic                      en;

    logic signed [hpt_pkg::SUM_W-1:0] acc [4];
    logic [CW-1:0] q [3];
    logic          s [3];
    logic          z [3];
    logic          div0;

    // Matrix registers; the index space is exactly the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[hpt_pkg::REG_R0_C01] <= hpt_pkg::ONE_LO;
            cfg_reg[hpt_pkg::REG_R0_C23] <= '0;
            cfg_reg[hpt_pkg::REG_R1_C01] <= hpt_pkg::ONE_HI;
            cfg_reg[hpt_pkg::REG_R1_C23] <= '0;
            cfg_reg[hpt_pkg::REG_R2_C01] <= '0;
            cfg_reg[hpt_pkg::REG_R2_C23] <= hpt_pkg::ONE_LO;
            cfg_reg[hpt_pkg::REG_R3_C01] <= '0;
            cfg_reg[hpt_pkg::REG_R3_C23] <= hpt_pkg::ONE_HI;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Entry (r, c) lives in register 2r + c/2, low half for even c.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = cfg_reg[hpt_pkg::IDX_W'(r*2 + c/2)][(c%2)*32 +: 32];
            end
        end
    end

    // Whole pipeline advances together: it moves whenever the output slot
    // is empty or being taken, so a stall freezes every stage in place.
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    hpt_mac u_mac (
        .clk     (clk),
        .en      (en),
        .point_x (s_axis_tdata[31:0]),
        .point_y (s_axis_tdata[63:32]),
        .point_z (s_axis_tdata[95:64]),
        .mat     (mat),
        .acc     (acc)
    );

    // One divider lane per coordinate, all sharing w as divisor.
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        hpt_div u_div (
            .clk  (clk),
            .en   (en),
            .num  (acc[g]),
            .den  (acc[3]),
            .quo  (q[g]),
            .sat  (s[g]),
            .zero (z[g])
        );
    end

    // Zero w forces zero coordinates and drops the saturation flag.
    assign div0 = z[0];

    always_comb
    begin
        if (div0)
        begin
            m_axis_tdata = '0;
            m_axis_tuser = 2'b01;
        end
        else
        begin
            m_axis_tdata = {q[2], q[1], q[0]};
            m_axis_tuser = {s[0] | s[1] | s[2], 1'b0};
        end
    end

    // The lanes see the same divisor, so their zero detects agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (z[0] == z[1]) && (z[1] == z[2]))
        else $error("divider lanes disagree on zero w");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata == '0)
        else $error("zero w word carries data or saturation");

    // A refused output word stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output did not hold");

endmodule
